// ----- hw/rtl/cmvr_pkg.sv -----
// shared widths, command and status types for the center-of-mass velocity removal block
package cmvr_pkg;

  localparam int VEL_W     = 24;               // signed Q8.16 velocity
  localparam int MASS_W    = 16;               // unsigned Q8.8 mass
  localparam int PROD_W    = 40;               // velocity times mass, exact
  localparam int SUM_W     = 46;               // weighted sum over a full set
  localparam int MTOT_W    = 22;               // mass total over a full set
  localparam int NUM_W     = SUM_W + 1;        // 2*|sum| + mass_total
  localparam int DEN_W     = MTOT_W + 1;       // 2*mass_total
  localparam int DIV_STEPS = NUM_W;            // one quotient bit per step
  localparam int ITER_W    = $clog2(DIV_STEPS);

  typedef logic signed [VEL_W-1:0] vel_t;

  typedef struct packed {
    logic load;        // capture an input transfer
    logic acc;         // add the registered products into the sums
    logic div_start;   // load the divider from the sums
    logic div_step;    // one restoring step on all three lanes
    logic div_fin;     // form the signed center-of-mass velocity
    logic rd;          // read one stored velocity
    logic next;        // advance the read address
    logic clear;       // end of set: zero the sums and the count
  } cmvr_cmd_t;

  typedef struct packed {
    logic close;       // the particle being accumulated ends the set
    logic div_done;    // the current divide step is the last one
    logic emit_last;   // the result on the output is the last of the set
  } cmvr_stat_t;

endpackage

// ----- hw/rtl/cmvr_if.sv -----
// valid/ready channel interfaces for particles in and adjusted velocities out
interface cmvr_in_if import cmvr_pkg::*; (input logic clk);
  logic              valid;
  logic              ready;
  vel_t              vel_x;
  vel_t              vel_y;
  vel_t              vel_z;
  logic [MASS_W-1:0] particle_mass;
  logic              in_last;

  modport source (output valid, vel_x, vel_y, vel_z, particle_mass, in_last, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, particle_mass, in_last, output ready);
endinterface

interface cmvr_out_if import cmvr_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  vel_t adj_vel_x;
  vel_t adj_vel_y;
  vel_t adj_vel_z;
  logic out_last;

  modport source (output valid, adj_vel_x, adj_vel_y, adj_vel_z, out_last, input ready);
  modport sink   (input valid, adj_vel_x, adj_vel_y, adj_vel_z, out_last, output ready);
endinterface

// ----- hw/rtl/cmvr_ctrl.sv -----
// controller state machine: load, accumulate, divide and emit phases
module cmvr_ctrl import cmvr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  cmvr_stat_t stat,
  output cmvr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = stat.close ? S_DINIT : S_IDLE;
      end
      S_DINIT: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.div_fin = 1'b1;
        state_next  = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.next   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/cmvr_datapath.sv -----
// datapath: velocity store, weighted sums, three-lane restoring divider, output saturation
module cmvr_datapath import cmvr_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cmvr_cmd_t         cmd,
  output cmvr_stat_t        stat,
  input  vel_t              vel_x,
  input  vel_t              vel_y,
  input  vel_t              vel_z,
  input  logic [MASS_W-1:0] particle_mass,
  input  logic              in_last,
  output vel_t              adj_vel_x,
  output vel_t              adj_vel_y,
  output vel_t              adj_vel_z
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  logic [3*VEL_W-1:0] store [MAX_PARTICLES];
  logic [3*VEL_W-1:0] rd_data;

  vel_t                     vin      [3];
  logic signed [PROD_W:0]   prod_full[3];
  logic signed [PROD_W-1:0] prod     [3];
  logic signed [SUM_W-1:0]  wsum     [3];
  logic [SUM_W-1:0]         mag      [3];
  logic [NUM_W-1:0]         num      [3];
  logic [DEN_W-1:0]         rem      [3];
  logic [DEN_W:0]           trial    [3];
  logic [DEN_W:0]           trial_sub[3];
  logic                     qbit     [3];
  logic [VEL_W-1:0]         quo      [3];
  vel_t                     com      [3];
  vel_t                     rd_vel   [3];
  logic signed [VEL_W:0]    diff     [3];
  vel_t                     adj      [3];

  logic [MASS_W-1:0] mass_q;
  logic              last_q;
  logic [MTOT_W-1:0] mass_total;
  logic [CW-1:0]     count;
  logic [ITER_W-1:0] iter;
  logic [AW-1:0]     raddr;
  logic [DEN_W-1:0]  den;

  assign vin[0] = vel_x;
  assign vin[1] = vel_y;
  assign vin[2] = vel_z;
  assign den    = {mass_total, 1'b0};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_full[k] = vin[k] * $signed({1'b0, particle_mass});
      mag[k]       = wsum[k][SUM_W-1] ? SUM_W'(-wsum[k]) : SUM_W'(wsum[k]);
      trial[k]     = {rem[k], num[k][NUM_W-1]};
      trial_sub[k] = trial[k] - {1'b0, den};
      qbit[k]      = (trial[k] >= {1'b0, den});
      rd_vel[k]    = rd_data[k*VEL_W +: VEL_W];
      diff[k]      = $signed({rd_vel[k][VEL_W-1], rd_vel[k]}) -
                     $signed({com[k][VEL_W-1], com[k]});
      // saturate when the two top bits disagree
      if (diff[k][VEL_W] != diff[k][VEL_W-1]) begin
        adj[k] = diff[k][VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
        adj[k] = diff[k][VEL_W-1:0];
      end
    end
  end

  assign adj_vel_x = adj[0];
  assign adj_vel_y = adj[1];
  assign adj_vel_z = adj[2];

  assign stat.close     = last_q || (count == CW'(MAX_PARTICLES - 1));
  assign stat.div_done  = (iter == ITER_W'(DIV_STEPS - 1));
  assign stat.emit_last = ((CW'(raddr) + CW'(1)) == count);

  // store and read port
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store[count[AW-1:0]] <= {vin[2], vin[1], vin[0]};
    end
    if (cmd.rd) begin
      rd_data <= store[raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mass_q <= particle_mass;
      last_q <= in_last;
      for (int k = 0; k < 3; k++) begin
        prod[k] <= prod_full[k][PROD_W-1:0];
      end
    end
    if (cmd.div_start) begin
      for (int k = 0; k < 3; k++) begin
        num[k] <= {mag[k], 1'b0} + NUM_W'(mass_total);
        rem[k] <= '0;
        quo[k] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        num[k] <= {num[k][NUM_W-2:0], 1'b0};
        rem[k] <= qbit[k] ? trial_sub[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
        quo[k] <= {quo[k][VEL_W-2:0], qbit[k]};
      end
    end
    if (cmd.div_fin) begin
      for (int k = 0; k < 3; k++) begin
        if (mass_total == '0) begin
          com[k] <= '0;
        end else begin
          com[k] <= wsum[k][SUM_W-1] ? VEL_W'(-quo[k]) : quo[k];
        end
      end
    end
  end

  // set state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int k = 0; k < 3; k++) begin
        wsum[k] <= '0;
      end
      mass_total <= '0;
      count      <= '0;
    end else if (cmd.acc) begin
      for (int k = 0; k < 3; k++) begin
        wsum[k] <= wsum[k] + {{(SUM_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]};
      end
      mass_total <= mass_total + MTOT_W'(mass_q);
      count      <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter  <= '0;
      raddr <= '0;
    end else begin
      if (cmd.div_start) begin
        iter <= '0;
      end else if (cmd.div_step) begin
        iter <= iter + ITER_W'(1);
      end
      if (cmd.div_fin) begin
        raddr <= '0;
      end else if (cmd.next) begin
        raddr <= raddr + AW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/center_of_mass_velocity_removal.sv -----
// top level: center-of-mass velocity removal over a set of particles
//
//   channel    dir   payload                                     transfer when
//   particles  in    vel_x/y/z, particle_mass, in_last           valid & ready
//   results    out   adj_vel_x/y/z, out_last                     valid & ready
//
// each particle is captured and multiplied, then accumulated
// closing a set adds a divider load, 47 restoring steps on three lanes and a finish
// each result takes one velocity store read, then the output is presented
// particles are refused while a set is being divided or emitted
// rst is synchronous and clears sums, count and control; the velocity store is not cleared
// a stalled result holds its payload until the transfer
module center_of_mass_velocity_removal import cmvr_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input logic        clk,
  input logic        rst,
  cmvr_in_if.sink    particles,
  cmvr_out_if.source results
);

  cmvr_cmd_t  cmd;
  cmvr_stat_t stat;

  cmvr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (particles.valid),
    .in_ready  (particles.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cmvr_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .vel_x         (particles.vel_x),
    .vel_y         (particles.vel_y),
    .vel_z         (particles.vel_z),
    .particle_mass (particles.particle_mass),
    .in_last       (particles.in_last),
    .adj_vel_x     (results.adj_vel_x),
    .adj_vel_y     (results.adj_vel_y),
    .adj_vel_z     (results.adj_vel_z)
  );

  assign results.out_last = stat.emit_last;

endmodule

// ----- hw/rtl/cmvr_checker.sv -----
// port-level checker for the center-of-mass velocity removal block, with its bind
module cmvr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [23:0] adj_vel_x
);

  // a stalled result keeps valid and its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(adj_vel_x) && $stable(out_last))
    else $error("stalled result changed");

  // particles are never taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while emitting");

  // every particle transfer is followed by an accumulate cycle
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("no accumulate cycle after particle");

  // the last result of a set returns the block to loading
  a_set_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("block not idle after last result");

endmodule

bind center_of_mass_velocity_removal cmvr_checker u_cmvr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (particles.valid),
  .in_ready  (particles.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_last  (results.out_last),
  .adj_vel_x (results.adj_vel_x)
);
